// File: sv/mls_pkg.sv
package mls_pkg;

   localparam int OFFSET_BITS = 32;
   localparam int OUT_BITS    = 32;
   localparam int BYTE_BITS   = 8;

   typedef logic [OFFSET_BITS-1:0] pos_type;
   typedef logic [OUT_BITS-1:0]    out_word_type;
   typedef logic [BYTE_BITS-1:0]   byte_type;

   localparam pos_type POS_MAX = '1;

   localparam byte_type CHAR_NEWLINE  = 8'h0A;
   localparam byte_type CHAR_TAB      = 8'h09;
   localparam byte_type CHAR_BLANK    = 8'h20;
   localparam byte_type CHAR_BANG     = 8'h21;
   localparam byte_type CHAR_OPEN_PAR = 8'h28;
   localparam byte_type CHAR_CLOSE_PAR = 8'h29;
   localparam byte_type CHAR_OPEN_BR  = 8'h5B;
   localparam byte_type CHAR_CLOSE_BR = 8'h5D;
   localparam byte_type CHAR_BACKTICK = 8'h60;

   // Leading backtick count; PREFIX_OVER means the line prefix is decided.
   localparam logic [1:0] FENCE_LAST  = 2'd2;
   localparam logic [1:0] PREFIX_OVER = 2'd3;

   typedef enum logic [2:0] {
      MODE_SEEK,
      MODE_TEXT,
      MODE_AFTER,
      MODE_TARGET,
      MODE_SKIP
   } scan_mode_type;

   typedef struct packed {
      byte_type byte_value;
      logic     final_byte;
   } in_item_type;

   typedef struct packed {
      logic        valid;
      in_item_type item;
   } in_stage_type;

   typedef struct packed {
      out_word_type text_start;
      out_word_type text_length;
      out_word_type target_start;
      out_word_type target_length;
   } result_type;

   typedef struct packed {
      logic       load;
      result_type result;
   } result_load_type;

endpackage

// File: sv/mls_req_if.sv
interface mls_req_if import mls_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type byte_value;
   logic     final_byte;

   modport source (output valid, output byte_value, output final_byte, input ready);
   modport sink (input valid, input byte_value, input final_byte, output ready);
endinterface

// File: sv/mls_rsp_if.sv
interface mls_rsp_if import mls_pkg::*; ();
   logic         valid;
   logic         ready;
   out_word_type text_start;
   out_word_type text_length;
   out_word_type target_start;
   out_word_type target_length;

   modport source (output valid, output text_start, output text_length,
                   output target_start, output target_length, input ready);
   modport sink (input valid, input text_start, input text_length,
                 input target_start, input target_length, output ready);
endinterface

// File: sv/mls_input_stage.sv
module mls_input_stage import mls_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   mls_req_if.sink      req_bus,
   input  logic         advance,
   output in_stage_type stage
);

   logic        valid_ff, valid_in;
   in_item_type item_ff, item_in;
   logic        take;

   // The register can refill in the same cycle its byte moves on.
   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in        = 1'b1;
         item_in.byte_value = req_bus.byte_value;
         item_in.final_byte = req_bus.final_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

// File: sv/mls_scan_core.sv
module mls_scan_core import mls_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  in_stage_type    stage,
   input  logic            out_free,
   output logic            advance,
   output result_load_type load
);

   pos_type       pos_ff, pos_in;
   logic          fence_ff, fence_in;
   scan_mode_type mode_ff, mode_in;
   logic [1:0]    count_ff, count_in;
   logic          bang_ff, bang_in;
   logic          image_ff, image_in;
   pos_type       open_ff, open_in;
   pos_type       close_ff, close_in;
   pos_type       first_ff, first_in;
   pos_type       last_ff, last_in;
   logic          seen_ff, seen_in;

   byte_type      b;
   logic          is_nl;
   logic          fence_toggle;
   logic          fence_eff;
   scan_mode_type mode_pre;
   logic          do_scan;
   logic          nonblank;
   logic          seek_open;
   logic          emit;
   pos_type       pos_next;
   pos_type       text_start;
   pos_type       text_length;
   pos_type       target_start;
   pos_type       target_length;

   function automatic pos_type sat_inc(input pos_type v);
      return (v == POS_MAX) ? POS_MAX : v + pos_type'(1);
   endfunction

   assign b            = stage.item.byte_value;
   assign is_nl        = (b == CHAR_NEWLINE);
   assign fence_toggle = !is_nl && (b == CHAR_BACKTICK) && (count_ff == FENCE_LAST);
   assign fence_eff    = fence_ff ^ fence_toggle;
   assign mode_pre     = fence_toggle ? MODE_SKIP : mode_ff;
   assign do_scan      = !is_nl && (mode_pre != MODE_SKIP) && !fence_eff;
   assign nonblank     = (b != CHAR_BLANK) && (b != CHAR_TAB);
   // A '[' opens a candidate from seek and also from a failed close.
   assign seek_open    = do_scan && (b == CHAR_OPEN_BR) &&
                         (mode_pre != MODE_TEXT) && (mode_pre != MODE_TARGET);
   assign emit         = do_scan && (mode_pre == MODE_TARGET) &&
                         (b == CHAR_CLOSE_PAR) && !image_ff;
   // A byte that leaves no result moves on even while the result register is full.
   assign advance      = stage.valid && (!emit || out_free);

   // Next scan mode.
   always_comb begin
      mode_in = mode_ff;
      if (advance) begin
         if (stage.item.final_byte || is_nl) begin
            mode_in = MODE_SEEK;
         end else if (!do_scan) begin
            mode_in = mode_pre;
         end else begin
            unique case (mode_pre)
               MODE_TEXT: begin
                  mode_in = (b == CHAR_CLOSE_BR) ? MODE_AFTER : MODE_TEXT;
               end
               MODE_AFTER: begin
                  if (b == CHAR_OPEN_PAR) begin
                     mode_in = MODE_TARGET;
                  end else begin
                     mode_in = (b == CHAR_OPEN_BR) ? MODE_TEXT : MODE_SEEK;
                  end
               end
               MODE_TARGET: begin
                  mode_in = (b == CHAR_CLOSE_PAR) ? MODE_SEEK : MODE_TARGET;
               end
               default: begin
                  mode_in = (b == CHAR_OPEN_BR) ? MODE_TEXT : MODE_SEEK;
               end
            endcase
         end
      end
   end

   // Line state, positions and the result.
   always_comb begin
      pos_next = sat_inc(pos_ff);
      pos_in   = pos_ff;
      fence_in = fence_ff;
      count_in = count_ff;
      bang_in  = bang_ff;
      image_in = image_ff;
      open_in  = open_ff;
      close_in = close_ff;
      first_in = first_ff;
      last_in  = last_ff;
      seen_in  = seen_ff;
      if (advance) begin
         pos_in   = pos_next;
         fence_in = fence_eff;
         if (is_nl) begin
            count_in = 2'd0;
            bang_in  = 1'b0;
            image_in = 1'b0;
            seen_in  = 1'b0;
         end else begin
            if (count_ff != PREFIX_OVER) begin
               count_in = (b == CHAR_BACKTICK) ? count_ff + 2'd1 : PREFIX_OVER;
            end
            if (do_scan) begin
               bang_in = (b == CHAR_BANG);
               if (seek_open) begin
                  open_in  = pos_ff;
                  image_in = bang_ff;
               end
               if ((mode_pre == MODE_TEXT) && (b == CHAR_CLOSE_BR)) begin
                  close_in = pos_ff;
               end
               if ((mode_pre == MODE_AFTER) && (b == CHAR_OPEN_PAR)) begin
                  seen_in = 1'b0;
               end
               if (mode_pre == MODE_TARGET) begin
                  if (b == CHAR_CLOSE_PAR) begin
                     seen_in = 1'b0;
                  end else if (nonblank) begin
                     if (!seen_ff) begin
                        first_in = pos_ff;
                     end
                     last_in = pos_ff;
                     seen_in = 1'b1;
                  end
               end
            end
         end
         if (stage.item.final_byte) begin
            pos_in   = '0;
            fence_in = 1'b0;
            count_in = 2'd0;
            bang_in  = 1'b0;
            image_in = 1'b0;
            seen_in  = 1'b0;
         end
      end

      text_start    = sat_inc(open_ff);
      text_length   = (close_ff > open_ff) ? close_ff - open_ff - pos_type'(1) : '0;
      target_start  = seen_ff ? first_ff : '0;
      target_length = seen_ff ? last_ff - first_ff + pos_type'(1) : '0;

      load.load                 = advance && emit;
      load.result.text_start    = out_word_type'(text_start);
      load.result.text_length   = out_word_type'(text_length);
      load.result.target_start  = out_word_type'(target_start);
      load.result.target_length = out_word_type'(target_length);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         fence_ff <= 1'b0;
         mode_ff  <= MODE_SEEK;
         count_ff <= 2'd0;
         bang_ff  <= 1'b0;
         image_ff <= 1'b0;
         seen_ff  <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         fence_ff <= fence_in;
         mode_ff  <= mode_in;
         count_ff <= count_in;
         bang_ff  <= bang_in;
         image_ff <= image_in;
         seen_ff  <= seen_in;
      end
      open_ff  <= open_in;
      close_ff <= close_in;
      first_ff <= first_in;
      last_ff  <= last_in;
   end

endmodule

// File: sv/mls_output_stage.sv
module mls_output_stage import mls_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  result_load_type load,
   output logic            out_free,
   mls_rsp_if.source       rsp_bus
);

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   assign out_free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load.load) begin
         valid_in  = 1'b1;
         result_in = load.result;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.text_start    = result_ff.text_start;
   assign rsp_bus.text_length   = result_ff.text_length;
   assign rsp_bus.target_start  = result_ff.target_start;
   assign rsp_bus.target_length = result_ff.target_length;

endmodule

// File: sv/markdown_link_scanner.sv
// Inline link scanner: takes one document byte per cycle unless a byte that closes a
// link waits for the result register, and presents each [text](target) link on the
// result channel through the input register and then the result register, with the
// text span and the blank-trimmed target span as byte offsets. The rate of one byte per
// cycle is set by the scan-mode and position registers, which are updated by one pass of
// logic per byte. A byte that yields no link moves on even while a finished result
// waits; a byte that yields one waits in the input register until the result register
// is free. Images, lines inside code fences and fence lines themselves yield nothing,
// and the position, fence and line state clear after the byte flagged as final.
module markdown_link_scanner import mls_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mls_req_if.sink   req_bus,
   mls_rsp_if.source rsp_bus
);

   in_stage_type    stage;
   logic            advance;
   logic            out_free;
   result_load_type load;

   mls_input_stage u_input (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .advance (advance),
      .stage   (stage)
   );

   mls_scan_core u_core (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .out_free (out_free),
      .advance  (advance),
      .load     (load)
   );

   mls_output_stage u_output (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .out_free (out_free),
      .rsp_bus  (rsp_bus)
   );

   // A result is only written into a free result register.
   assert property (@(posedge clock) disable iff (reset) load.load |-> out_free)
      else $error("result written over one not yet taken");

   // A result needs a byte in the input register.
   assert property (@(posedge clock) disable iff (reset) !stage.valid |-> !load.load)
      else $error("result produced without a byte");

   // A written result is presented in the next cycle.
   assert property (@(posedge clock) disable iff (reset) load.load |=> rsp_bus.valid)
      else $error("written result not presented");

   // An accepted transaction always lands in the input register.
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> stage.valid)
      else $error("accepted byte lost");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import mls_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int REPORT_LIMIT = 10;

   localparam string TEXT_CHARS   = "ab Z9!([)\t";
   localparam string TARGET_CHARS = "xy/.:# [](!\t";
   localparam string BLANK_CHARS  = " \t";
   localparam string AFTER_CHARS  = "x [!";

   logic clock = 1'b0;
   logic reset;

   mls_req_if req_bus ();
   mls_rsp_if rsp_bus ();

   markdown_link_scanner dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   in_item_type  pending_bytes[$];
   result_type   expected_links[$];
   int           bytes_queued = 0;
   int           fault_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           hold_left = 0;
   logic         hold_go = 1'b0;
   string        field_name[4] = '{"text_start", "text_length", "target_start",
                                   "target_length"};

   // Scanner state as the block should hold it.
   pos_type       doc_pos;
   logic          in_fence;
   scan_mode_type mode;
   logic [1:0]    tick_count;
   logic          last_bang;
   logic          cand_image;
   pos_type       open_pos;
   pos_type       close_pos;
   pos_type       tgt_first;
   pos_type       tgt_last;
   logic          tgt_seen;

   function automatic pos_type step_pos(input pos_type p);
      return (p == POS_MAX) ? p : p + 1'b1;
   endfunction

   task automatic clear_line_state();
      mode       = MODE_SEEK;
      tick_count = 2'd0;
      last_bang  = 1'b0;
      cand_image = 1'b0;
      tgt_seen   = 1'b0;
   endtask

   task automatic reset_scanner();
      doc_pos   = '0;
      in_fence  = 1'b0;
      open_pos  = '0;
      close_pos = '0;
      tgt_first = '0;
      tgt_last  = '0;
      clear_line_state();
   endtask

   task automatic open_candidate(input byte_type b, input pos_type pos);
      if (b == CHAR_OPEN_BR) begin
         open_pos   = pos;
         cand_image = last_bang;
         mode       = MODE_TEXT;
      end else begin
         mode = MODE_SEEK;
      end
   endtask

   // Advances the scanner by one byte; found is set when the byte closes a link.
   task automatic scan_byte(input byte_type b, input logic fin, output bit found,
                            output result_type link);
      pos_type pos;
      pos   = doc_pos;
      found = 1'b0;
      link  = '0;
      if (b == CHAR_NEWLINE) begin
         clear_line_state();
      end else begin
         if (tick_count != PREFIX_OVER) begin
            if (b != CHAR_BACKTICK) begin
               tick_count = PREFIX_OVER;
            end else if (tick_count == FENCE_LAST) begin
               tick_count = PREFIX_OVER;
               in_fence   = !in_fence;
               mode       = MODE_SKIP;
            end else begin
               tick_count = tick_count + 2'd1;
            end
         end
         if (mode != MODE_SKIP && !in_fence) begin
            case (mode)
               MODE_TEXT: begin
                  if (b == CHAR_CLOSE_BR) begin
                     close_pos = pos;
                     mode      = MODE_AFTER;
                  end
               end
               MODE_AFTER: begin
                  if (b == CHAR_OPEN_PAR) begin
                     mode     = MODE_TARGET;
                     tgt_seen = 1'b0;
                  end else begin
                     open_candidate(b, pos);
                  end
               end
               MODE_TARGET: begin
                  if (b == CHAR_CLOSE_PAR) begin
                     if (!cand_image) begin
                        found            = 1'b1;
                        link.text_start  = out_word_type'(step_pos(open_pos));
                        link.text_length = (close_pos > open_pos) ?
                                           out_word_type'(close_pos - open_pos - 1'b1) : '0;
                        if (tgt_seen) begin
                           link.target_start  = out_word_type'(tgt_first);
                           link.target_length = out_word_type'(tgt_last - tgt_first + 1'b1);
                        end
                     end
                     mode     = MODE_SEEK;
                     tgt_seen = 1'b0;
                  end else if (b != CHAR_BLANK && b != CHAR_TAB) begin
                     if (!tgt_seen) begin
                        tgt_first = pos;
                        tgt_seen  = 1'b1;
                     end
                     tgt_last = pos;
                  end
               end
               default: begin
                  open_candidate(b, pos);
               end
            endcase
            last_bang = (b == CHAR_BANG);
         end
      end
      doc_pos = step_pos(pos);
      if (fin) begin
         reset_scanner();
      end
   endtask

   // Stimulus building.
   task automatic push_byte(input byte_type b, input logic fin);
      pending_bytes.insert(pending_bytes.size(), in_item_type'{byte_value: b, final_byte: fin});
      bytes_queued++;
   endtask

   task automatic push_chars(input string s);
      for (int i = 0; i < s.len(); i++) begin
         push_byte(byte_type'(s[i]), 1'b0);
      end
   endtask

   task automatic push_content(input string alphabet, input int count);
      for (int i = 0; i < count; i++) begin
         push_byte(byte_type'(alphabet[$urandom_range(0, alphabet.len() - 1)]), 1'b0);
      end
   endtask

   task automatic push_ticks(input int count);
      for (int i = 0; i < count; i++) begin
         push_byte(CHAR_BACKTICK, 1'b0);
      end
   endtask

   task automatic add_link(input bit image);
      if (image) begin
         push_byte(CHAR_BANG, 1'b0);
      end
      push_byte(CHAR_OPEN_BR, 1'b0);
      push_content(TEXT_CHARS, $urandom_range(0, 4));
      push_byte(CHAR_CLOSE_BR, 1'b0);
      push_byte(CHAR_OPEN_PAR, 1'b0);
      push_content(BLANK_CHARS, $urandom_range(0, 2));
      push_content(TARGET_CHARS, $urandom_range(0, 4));
      push_content(BLANK_CHARS, $urandom_range(0, 2));
      push_byte(CHAR_CLOSE_PAR, 1'b0);
   endtask

   task automatic add_segment();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1: begin
            push_content(TEXT_CHARS, $urandom_range(1, 5));
         end
         2, 3, 4, 5: begin
            add_link($urandom_range(0, 4) == 0);
         end
         6: begin
            // Text closed but no parenthesis follows.
            push_byte(CHAR_OPEN_BR, 1'b0);
            push_content(TEXT_CHARS, $urandom_range(0, 3));
            push_byte(CHAR_CLOSE_BR, 1'b0);
            push_content(AFTER_CHARS, 1);
         end
         7: begin
            // A failed candidate immediately followed by a new one.
            push_byte(CHAR_OPEN_BR, 1'b0);
            push_content(TEXT_CHARS, $urandom_range(0, 3));
            push_byte(CHAR_CLOSE_BR, 1'b0);
            add_link(1'b0);
         end
         8: begin
            push_content(BLANK_CHARS, $urandom_range(1, 3));
         end
         default: begin
            push_byte(CHAR_BANG, 1'b0);
            push_content(TEXT_CHARS, $urandom_range(1, 2));
         end
      endcase
   endtask

   task automatic add_line();
      int kind;
      int count;
      kind = $urandom_range(0, 99);
      if (kind < 7) begin
         push_ticks(3);
         push_content(TEXT_CHARS, $urandom_range(0, 3));
         push_byte(CHAR_NEWLINE, 1'b0);
      end else if (kind < 20) begin
         count = $urandom_range(1, 8);
         for (int i = 0; i < count; i++) begin
            push_byte(byte_type'($urandom_range(0, 255)), 1'b0);
         end
         push_byte(CHAR_NEWLINE, 1'b0);
      end else begin
         if (kind < 26) begin
            push_ticks(2);
         end else if (kind < 30) begin
            push_byte(CHAR_BLANK, 1'b0);
            push_ticks(3);
         end
         count = $urandom_range(1, 4);
         for (int i = 0; i < count; i++) begin
            add_segment();
         end
         if ($urandom_range(0, 6) == 0) begin
            // The line runs out inside a candidate.
            push_byte(CHAR_OPEN_BR, 1'b0);
            push_content(TEXT_CHARS, $urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1) begin
               push_byte(CHAR_CLOSE_BR, 1'b0);
               push_byte(CHAR_OPEN_PAR, 1'b0);
               push_content(TARGET_CHARS, $urandom_range(0, 3));
            end
         end
         if (kind >= 90) begin
            if ($urandom_range(0, 1) == 1) begin
               push_byte(CHAR_NEWLINE, 1'b0);
            end
            pending_bytes[pending_bytes.size() - 1].final_byte = 1'b1;
         end else begin
            push_byte(CHAR_NEWLINE, 1'b0);
         end
      end
   endtask

   task automatic add_lines(input int count);
      int start;
      start = bytes_queued;
      while (bytes_queued - start < count) begin
         add_line();
      end
   endtask

   task automatic wait_sent();
      while (pending_bytes.size() != 0 || req_bus.valid) begin
         @(negedge clock);
      end
   endtask

   task automatic wait_links();
      while (expected_links.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Byte driver.
   always @(posedge clock) begin : byte_driver
      in_item_type next_byte;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_byte = pending_bytes.pop_front();
            req_bus.valid      <= 1'b1;
            req_bus.byte_value <= next_byte.byte_value;
            req_bus.final_byte <= next_byte.final_byte;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Long hold-off of the result side, counted here.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : link_predict
      bit         found;
      result_type link;
      if (!reset && req_bus.valid && req_bus.ready) begin
         scan_byte(req_bus.byte_value, req_bus.final_byte, found, link);
         if (found) begin
            expected_links.insert(expected_links.size(), link);
         end
      end
   end

   always @(posedge clock) begin : link_check
      result_type   want;
      out_word_type want_word[4];
      out_word_type got_word[4];
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_links.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT) begin
               $display("unexpected link transaction: text %0d+%0d target %0d+%0d",
                        rsp_bus.text_start, rsp_bus.text_length,
                        rsp_bus.target_start, rsp_bus.target_length);
            end
         end else begin
            want = expected_links.pop_front();
            want_word = '{want.text_start, want.text_length,
                          want.target_start, want.target_length};
            got_word  = '{rsp_bus.text_start, rsp_bus.text_length,
                          rsp_bus.target_start, rsp_bus.target_length};
            for (int i = 0; i < 4; i++) begin
               if (got_word[i] !== want_word[i]) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $display("link %s mismatch: expected %0d, got %0d",
                              field_name[i], want_word[i], got_word[i]);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[markdown_link_scanner] ERROR");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.byte_value = '0;
      req_bus.final_byte = 1'b0;
      rsp_bus.ready      = 1'b0;
      reset_scanner();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty text with a blank target, an image, a failed candidate reopened,
      // and the byte extremes with the document end flag.
      push_chars("[]( \t)![](y)[a][b](z)");
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b1);
      wait_sent();

      send_idle_pct = 21;
      recv_idle_pct = 85;
      add_lines(660);
      wait_sent();

      send_idle_pct = 85;
      recv_idle_pct = 21;
      add_lines(330);
      wait_sent();
      wait_links();
      add_lines(330);
      wait_sent();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_lines(660);
      @(negedge clock);
      hold_go = 1'b1;
      @(negedge clock);
      hold_go = 1'b0;
      wait_sent();
      wait_links();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0) begin
         $display("[markdown_link_scanner] OK");
      end else begin
         $display("[markdown_link_scanner] ERROR");
      end
      $finish;
   end

endmodule
